// ===== rtl/qsge_pkg.sv =====
package qsge_pkg;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_READ    = 3'd1,
    FN_HAD     = 3'd2,
    FN_PHASE   = 3'd3,
    FN_CPHASE  = 3'd4,
    FN_CZ      = 3'd5,
    FN_CNOT    = 3'd6,
    FN_FREDKIN = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_SCAN,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_NEG,
    ST_MATH,
    ST_WR_A,
    ST_WR_B,
    ST_FINISH
  } state_t;

  // Operand pairs for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_AR_C,
    MUL_AI_S,
    MUL_AR_S,
    MUL_AI_C,
    MUL_SUM_RE,
    MUL_SUM_IM,
    MUL_DIF_RE,
    MUL_DIF_IM
  } mul_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ACC_LOAD,
    RES_SUB,
    RES_ADD,
    RES_PROD,
    RES_NEG
  } res_op_t;

  typedef enum logic [2:0] {
    WS_IN,
    WS_RES_LO,
    WS_RES_HI,
    WS_A,
    WS_B
  } wsel_t;

  typedef struct packed {
    logic    cap_in;
    logic    cap_a;
    logic    cap_b;
    mul_op_t mul_op;
    res_op_t res_op;
    logic [1:0] res_idx;
    wsel_t   wsel;
    logic    clr_sat;
    logic    out_load;
    logic    out_read;
    logic    out_bad;
  } dp_cmd_t;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BAD = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  localparam logic [3:0] MAX_ORDER = 4'd10;
  localparam logic [4:0] MIN_QUBITS = 5'd3;

  localparam logic signed [31:0] HAD_K = 32'sd759250125;

  // Q30 cosine of 2*pi/2^m.
  function automatic logic signed [31:0] cos_q30(input logic [3:0] m);
    logic signed [31:0] v;
    case (m)
      4'd1:    v = -32'sd1073741824;
      4'd2:    v = 32'sd0;
      4'd3:    v = 32'sd759250125;
      4'd4:    v = 32'sd992008095;
      4'd5:    v = 32'sd1053110175;
      4'd6:    v = 32'sd1068571464;
      4'd7:    v = 32'sd1072448455;
      4'd8:    v = 32'sd1073418433;
      4'd9:    v = 32'sd1073660973;
      4'd10:   v = 32'sd1073721611;
      default: v = 32'sd1073741824;
    endcase
    return v;
  endfunction

  // Q30 sine of 2*pi/2^m.
  function automatic logic signed [31:0] sin_q30(input logic [3:0] m);
    logic signed [31:0] v;
    case (m)
      4'd2:    v = 32'sd1073741824;
      4'd3:    v = 32'sd759250125;
      4'd4:    v = 32'sd410903206;
      4'd5:    v = 32'sd209476638;
      4'd6:    v = 32'sd105245103;
      4'd7:    v = 32'sd52686014;
      4'd8:    v = 32'sd26350944;
      4'd9:    v = 32'sd13176464;
      4'd10:   v = 32'sd6588356;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/qsge_ram.sv =====
module qsge_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/qsge_dp.sv =====
module qsge_dp #(
  parameter int AMP_BITS = 18
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qsge_pkg::dp_cmd_t       cmd,
  input  logic [AMP_BITS-1:0]     in_write_re,
  input  logic [AMP_BITS-1:0]     in_write_im,
  input  logic [3:0]              in_angle_order,
  input  logic                    in_inverse,
  input  logic [2*AMP_BITS-1:0]   ram_rdata,
  output logic [2*AMP_BITS-1:0]   ram_wdata,
  output logic [AMP_BITS-1:0]     read_re,
  output logic [AMP_BITS-1:0]     read_im,
  output logic [1:0]              status
);

  localparam int PW = AMP_BITS + 33;
  localparam int SW = PW + 1;

  logic signed [AMP_BITS-1:0] wr_re_r, wr_im_r;
  logic signed [AMP_BITS-1:0] a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [AMP_BITS-1:0] res_r [4];
  logic signed [31:0]         c_r, s_r;
  logic signed [PW-1:0]       prod_r, acc_r;
  logic                       sat_r;

  logic signed [AMP_BITS:0]   mul_a;
  logic signed [31:0]         mul_b;
  logic signed [SW-1:0]       sum;
  logic [AMP_BITS:0]          clipped;
  logic [AMP_BITS:0]          neg_re, neg_im;

  // Saturate to the amplitude range; the top bit of the result flags a clip.
  function automatic logic [AMP_BITS:0] clip(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    logic [AMP_BITS:0]    r;
    hi = {{(SW-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      r = {1'b1, hi[AMP_BITS-1:0]};
    end else if (x < lo) begin
      r = {1'b1, lo[AMP_BITS-1:0]};
    end else begin
      r = {1'b0, x[AMP_BITS-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    case (cmd.mul_op)
      qsge_pkg::MUL_AR_C:   begin mul_a = (AMP_BITS+1)'(a_re_r); mul_b = c_r; end
      qsge_pkg::MUL_AI_S:   begin mul_a = (AMP_BITS+1)'(a_im_r); mul_b = s_r; end
      qsge_pkg::MUL_AR_S:   begin mul_a = (AMP_BITS+1)'(a_re_r); mul_b = s_r; end
      qsge_pkg::MUL_AI_C:   begin mul_a = (AMP_BITS+1)'(a_im_r); mul_b = c_r; end
      qsge_pkg::MUL_SUM_RE: begin
        mul_a = (AMP_BITS+1)'(a_re_r) + (AMP_BITS+1)'(b_re_r);
        mul_b = qsge_pkg::HAD_K;
      end
      qsge_pkg::MUL_SUM_IM: begin
        mul_a = (AMP_BITS+1)'(a_im_r) + (AMP_BITS+1)'(b_im_r);
        mul_b = qsge_pkg::HAD_K;
      end
      qsge_pkg::MUL_DIF_RE: begin
        mul_a = (AMP_BITS+1)'(a_re_r) - (AMP_BITS+1)'(b_re_r);
        mul_b = qsge_pkg::HAD_K;
      end
      default: begin
        mul_a = (AMP_BITS+1)'(a_im_r) - (AMP_BITS+1)'(b_im_r);
        mul_b = qsge_pkg::HAD_K;
      end
    endcase
  end

  always_comb begin
    case (cmd.res_op)
      qsge_pkg::RES_SUB: sum = SW'(acc_r) - SW'(prod_r);
      qsge_pkg::RES_ADD: sum = SW'(acc_r) + SW'(prod_r);
      default:           sum = SW'(prod_r);
    endcase
    // Round half up at the Q46 to Q16 step, then saturate.
    clipped = clip((sum + (SW'(1) <<< 29)) >>> 30);
    neg_re  = clip(-SW'(a_re_r));
    neg_im  = clip(-SW'(a_im_r));
  end

  always_comb begin
    case (cmd.wsel)
      qsge_pkg::WS_IN:     ram_wdata = {wr_im_r, wr_re_r};
      qsge_pkg::WS_RES_LO: ram_wdata = {res_r[1], res_r[0]};
      qsge_pkg::WS_RES_HI: ram_wdata = {res_r[3], res_r[2]};
      qsge_pkg::WS_A:      ram_wdata = {a_im_r, a_re_r};
      default:             ram_wdata = {b_im_r, b_re_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      wr_re_r <= in_write_re;
      wr_im_r <= in_write_im;
      c_r     <= qsge_pkg::cos_q30(in_angle_order);
      s_r     <= in_inverse ? -qsge_pkg::sin_q30(in_angle_order)
                            : qsge_pkg::sin_q30(in_angle_order);
    end
    if (cmd.cap_a) begin
      a_re_r <= ram_rdata[AMP_BITS-1:0];
      a_im_r <= ram_rdata[2*AMP_BITS-1:AMP_BITS];
    end
    if (cmd.cap_b) begin
      b_re_r <= ram_rdata[AMP_BITS-1:0];
      b_im_r <= ram_rdata[2*AMP_BITS-1:AMP_BITS];
    end
    prod_r <= mul_a * mul_b;
    case (cmd.res_op)
      qsge_pkg::RES_ACC_LOAD: acc_r <= prod_r;
      qsge_pkg::RES_SUB, qsge_pkg::RES_ADD, qsge_pkg::RES_PROD: begin
        res_r[cmd.res_idx] <= clipped[AMP_BITS-1:0];
      end
      qsge_pkg::RES_NEG: begin
        res_r[0] <= neg_re[AMP_BITS-1:0];
        res_r[1] <= neg_im[AMP_BITS-1:0];
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      read_re <= cmd.out_read ? a_re_r : '0;
      read_im <= cmd.out_read ? a_im_r : '0;
      status  <= cmd.out_bad ? qsge_pkg::STAT_BAD :
                 sat_r       ? qsge_pkg::STAT_SAT : qsge_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.clr_sat) begin
      sat_r <= 1'b0;
    end else begin
      case (cmd.res_op)
        qsge_pkg::RES_SUB, qsge_pkg::RES_ADD, qsge_pkg::RES_PROD: begin
          if (clipped[AMP_BITS]) sat_r <= 1'b1;
        end
        qsge_pkg::RES_NEG: begin
          if (neg_re[AMP_BITS] || neg_im[AMP_BITS]) sat_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/qsge_ctrl.sv =====
module qsge_ctrl #(
  parameter int MAX_QUBITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_func,
  input  logic [9:0]             in_amp_index,
  input  logic [3:0]             in_qubit_first,
  input  logic [3:0]             in_qubit_second,
  input  logic [3:0]             in_qubit_third,
  input  logic [3:0]             in_angle_order,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   ram_we,
  output logic                   ram_re,
  output logic [MAX_QUBITS-1:0]  ram_addr,
  output qsge_pkg::dp_cmd_t      cmd
);

  localparam int AW = MAX_QUBITS;

  qsge_pkg::state_t state_r, state_nxt;
  qsge_pkg::func_t  func_r;
  logic [AW-1:0]    idx_r, i_r, i_nxt;
  logic [3:0]       q1_r, q2_r, q3_r;
  logic             bad_r, bad_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [3:0]       cfg_n_r;
  logic             out_valid_r, out_valid_nxt;

  logic [4:0]       n_eff;
  logic [AW-1:0]    last, b1, b2, b3, partner;
  logic [AW+9:0]    idx_ext;
  logic             active, pair, accept;
  qsge_pkg::func_t  in_fn;

  assign in_fn    = qsge_pkg::func_t'(in_func);
  assign accept   = in_valid && (state_r == qsge_pkg::ST_IDLE);
  assign in_stall = (state_r != qsge_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign idx_ext  = {{AW{1'b0}}, in_amp_index};

  always_comb begin
    if ({1'b0, cfg_n_r} < qsge_pkg::MIN_QUBITS) begin
      n_eff = qsge_pkg::MIN_QUBITS;
    end else if ({1'b0, cfg_n_r} > 5'(MAX_QUBITS)) begin
      n_eff = 5'(MAX_QUBITS);
    end else begin
      n_eff = {1'b0, cfg_n_r};
    end
  end

  assign last = (AW'(1) << n_eff) - AW'(1);
  assign b1   = AW'(1) << q1_r;
  assign b2   = AW'(1) << q2_r;
  assign b3   = AW'(1) << q3_r;

  always_comb begin
    bad_nxt = 1'b0;
    if (in_func >= 3'd2) begin
      if ({1'b0, in_qubit_first} >= n_eff) bad_nxt = 1'b1;
      if (in_func >= 3'd4 && ({1'b0, in_qubit_second} >= n_eff ||
                              in_qubit_second <= in_qubit_first)) bad_nxt = 1'b1;
      if (in_fn == qsge_pkg::FN_FREDKIN && ({1'b0, in_qubit_third} >= n_eff ||
                                            in_qubit_third <= in_qubit_second)) bad_nxt = 1'b1;
      if ((in_fn == qsge_pkg::FN_PHASE || in_fn == qsge_pkg::FN_CPHASE) &&
          (in_angle_order < 4'd1 || in_angle_order > qsge_pkg::MAX_ORDER)) bad_nxt = 1'b1;
    end
  end

  always_comb begin
    active  = 1'b0;
    pair    = 1'b0;
    partner = i_r;
    case (func_r)
      qsge_pkg::FN_HAD: begin
        active  = (i_r & b1) == '0;
        pair    = 1'b1;
        partner = i_r | b1;
      end
      qsge_pkg::FN_PHASE: active = (i_r & b1) != '0;
      qsge_pkg::FN_CPHASE, qsge_pkg::FN_CZ: begin
        active = ((i_r & b1) != '0) && ((i_r & b2) != '0);
      end
      qsge_pkg::FN_CNOT: begin
        active  = ((i_r & b1) != '0) && ((i_r & b2) == '0);
        pair    = 1'b1;
        partner = i_r | b2;
      end
      qsge_pkg::FN_FREDKIN: begin
        active  = ((i_r & b1) != '0) && ((i_r & b2) != '0) && ((i_r & b3) == '0);
        pair    = 1'b1;
        partner = (i_r & ~b2) | b3;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = i_r;
    cmd           = '0;
    cmd.mul_op    = qsge_pkg::MUL_AR_C;
    cmd.res_op    = qsge_pkg::RES_NONE;
    cmd.wsel      = qsge_pkg::WS_IN;
    unique case (state_r)
      qsge_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_in  = 1'b1;
          cmd.clr_sat = 1'b1;
          i_nxt       = '0;
          unique case (in_fn)
            qsge_pkg::FN_WRITE: state_nxt = qsge_pkg::ST_WRITE;
            qsge_pkg::FN_READ:  state_nxt = qsge_pkg::ST_RD_ADDR;
            default: state_nxt = bad_nxt ? qsge_pkg::ST_FINISH : qsge_pkg::ST_SCAN;
          endcase
        end
      end
      qsge_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = idx_r;
        cmd.wsel  = qsge_pkg::WS_IN;
        state_nxt = qsge_pkg::ST_FINISH;
      end
      qsge_pkg::ST_RD_ADDR: begin
        ram_re    = 1'b1;
        ram_addr  = idx_r;
        state_nxt = qsge_pkg::ST_RD_DATA;
      end
      qsge_pkg::ST_RD_DATA: begin
        cmd.cap_a = 1'b1;
        state_nxt = qsge_pkg::ST_FINISH;
      end
      qsge_pkg::ST_SCAN: begin
        if (active) begin
          ram_re    = 1'b1;
          state_nxt = qsge_pkg::ST_LOAD_A;
        end else if (i_r == last) begin
          state_nxt = qsge_pkg::ST_FINISH;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      qsge_pkg::ST_LOAD_A: begin
        cmd.cap_a = 1'b1;
        cnt_nxt   = '0;
        if (pair) begin
          ram_re    = 1'b1;
          ram_addr  = partner;
          state_nxt = qsge_pkg::ST_LOAD_B;
        end else if (func_r == qsge_pkg::FN_CZ) begin
          state_nxt = qsge_pkg::ST_NEG;
        end else begin
          state_nxt = qsge_pkg::ST_MATH;
        end
      end
      qsge_pkg::ST_LOAD_B: begin
        cmd.cap_b = 1'b1;
        state_nxt = (func_r == qsge_pkg::FN_HAD) ? qsge_pkg::ST_MATH : qsge_pkg::ST_WR_A;
      end
      qsge_pkg::ST_NEG: begin
        cmd.res_op = qsge_pkg::RES_NEG;
        state_nxt  = qsge_pkg::ST_WR_A;
      end
      qsge_pkg::ST_MATH: begin
        // One product per cycle; the product register lags the operand select.
        cnt_nxt = cnt_r + 3'd1;
        if (func_r == qsge_pkg::FN_HAD) begin
          case (cnt_r)
            3'd0: cmd.mul_op = qsge_pkg::MUL_SUM_RE;
            3'd1: cmd.mul_op = qsge_pkg::MUL_SUM_IM;
            3'd2: cmd.mul_op = qsge_pkg::MUL_DIF_RE;
            default: cmd.mul_op = qsge_pkg::MUL_DIF_IM;
          endcase
          if (cnt_r != 3'd0) begin
            cmd.res_op  = qsge_pkg::RES_PROD;
            cmd.res_idx = 2'(cnt_r - 3'd1);
          end
        end else begin
          case (cnt_r)
            3'd0: cmd.mul_op = qsge_pkg::MUL_AR_C;
            3'd1: begin
              cmd.mul_op = qsge_pkg::MUL_AI_S;
              cmd.res_op = qsge_pkg::RES_ACC_LOAD;
            end
            3'd2: begin
              cmd.mul_op  = qsge_pkg::MUL_AR_S;
              cmd.res_op  = qsge_pkg::RES_SUB;
              cmd.res_idx = 2'd0;
            end
            3'd3: begin
              cmd.mul_op = qsge_pkg::MUL_AI_C;
              cmd.res_op = qsge_pkg::RES_ACC_LOAD;
            end
            default: begin
              cmd.res_op  = qsge_pkg::RES_ADD;
              cmd.res_idx = 2'd1;
            end
          endcase
        end
        if (cnt_r == 3'd4) state_nxt = qsge_pkg::ST_WR_A;
      end
      qsge_pkg::ST_WR_A: begin
        ram_we   = 1'b1;
        cmd.wsel = (pair && func_r != qsge_pkg::FN_HAD) ? qsge_pkg::WS_B
                                                        : qsge_pkg::WS_RES_LO;
        if (pair) begin
          state_nxt = qsge_pkg::ST_WR_B;
        end else if (i_r == last) begin
          state_nxt = qsge_pkg::ST_FINISH;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = qsge_pkg::ST_SCAN;
        end
      end
      qsge_pkg::ST_WR_B: begin
        ram_we   = 1'b1;
        ram_addr = partner;
        cmd.wsel = (func_r == qsge_pkg::FN_HAD) ? qsge_pkg::WS_RES_HI : qsge_pkg::WS_A;
        if (i_r == last) begin
          state_nxt = qsge_pkg::ST_FINISH;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = qsge_pkg::ST_SCAN;
        end
      end
      qsge_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          cmd.out_read  = (func_r == qsge_pkg::FN_READ);
          cmd.out_bad   = bad_r;
          out_valid_nxt = 1'b1;
          state_nxt     = qsge_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qsge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qsge_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_n_r     <= 4'd10;
      i_r         <= '0;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) cfg_n_r <= cfg_data;
      if (accept) bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_fn;
      idx_r  <= idx_ext[AW-1:0];
      q1_r   <= in_qubit_first;
      q2_r   <= in_qubit_second;
      q3_r   <= in_qubit_third;
    end
  end

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qsge_pkg::ST_IDLE |-> !ram_we)
    else $error("store written while idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == qsge_pkg::ST_FINISH))
    else $error("result raised outside finish");

  a_scan_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> i_r == '0)
    else $error("scan index not cleared on accept");

  a_bad_skips_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qsge_pkg::ST_SCAN && bad_r) |-> 1'b0)
    else $error("rejected gate entered scan");
`endif

endmodule

// ===== rtl/quantum_state_gate_engine.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  func, amp_index, write_re/im, qubits, order
// out_      output     out_valid/out_stall  read_re, read_im, status
// cfg_      input      cfg_we               cfg_data (qubits_in_use)
//
// A write, a read and a rejected gate do not scan the vector. A gate visits each entry
// of the 2^n vector in turn; each rotated or negated entry, Hadamard pair and swapped pair
// adds reads and writes, and rotations and Hadamard pairs add products; the single port
// of the amplitude store and the one shared multiplier put this work in sequence.
// Reset is synchronous and active low; it clears control state and sets
// qubits_in_use to 10. The amplitude store is not cleared.
// One item is worked on at a time; a finished result waits in the output register
// while the next item is accepted, and the block holds at its end only if that
// register is still full and stalled.
module quantum_state_gate_engine #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_func,
  input  logic [9:0]          in_amp_index,
  input  logic [AMP_BITS-1:0] in_write_re,
  input  logic [AMP_BITS-1:0] in_write_im,
  input  logic [3:0]          in_qubit_first,
  input  logic [3:0]          in_qubit_second,
  input  logic [3:0]          in_qubit_third,
  input  logic [3:0]          in_angle_order,
  input  logic                in_inverse,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [AMP_BITS-1:0] out_read_re,
  output logic [AMP_BITS-1:0] out_read_im,
  output logic [1:0]          out_status
);

  // The controller walks the vector and sequences reads, products and writes;
  // the datapath holds operands, the multiplier, rounding and the result register.
  qsge_pkg::dp_cmd_t       cmd;
  logic                    ram_we, ram_re;
  logic [MAX_QUBITS-1:0]   ram_addr;
  logic [2*AMP_BITS-1:0]   ram_wdata, ram_rdata;

  qsge_ctrl #(
    .MAX_QUBITS(MAX_QUBITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_amp_index   (in_amp_index),
    .in_qubit_first (in_qubit_first),
    .in_qubit_second(in_qubit_second),
    .in_qubit_third (in_qubit_third),
    .in_angle_order (in_angle_order),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ram_we         (ram_we),
    .ram_re         (ram_re),
    .ram_addr       (ram_addr),
    .cmd            (cmd)
  );

  qsge_dp #(
    .AMP_BITS(AMP_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_write_re   (in_write_re),
    .in_write_im   (in_write_im),
    .in_angle_order(in_angle_order),
    .in_inverse    (in_inverse),
    .ram_rdata     (ram_rdata),
    .ram_wdata     (ram_wdata),
    .read_re       (out_read_re),
    .read_im       (out_read_im),
    .status        (out_status)
  );

  // Each entry holds the imaginary part above the real part.
  qsge_ram #(
    .WIDTH(2 * AMP_BITS),
    .DEPTH(1 << MAX_QUBITS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule
